// File: src/bpdc_pkg.sv
// Shared types and constants for the button press duration classifier.
// Used by every module of the block; depends on nothing.
`default_nettype none

package bpdc_pkg;

   // Request kinds carried on req_tuser
   localparam logic [1:0] CMD_TICK = 2'd0;
   localparam logic [1:0] CMD_EDGE = 2'd1;
   localparam logic [1:0] CMD_POLL = 2'd2;

   // Classification codes returned on a poll
   localparam logic [1:0] EV_NONE  = 2'd0;
   localparam logic [1:0] EV_SHORT = 2'd1;
   localparam logic [1:0] EV_LONG  = 2'd2;
   localparam logic [1:0] EV_STOP  = 2'd3;

   // Register map of the configuration port
   localparam logic [1:0] REG_DEBOUNCE    = 2'd0;
   localparam logic [1:0] REG_SHORT_LIMIT = 2'd1;
   localparam logic [1:0] REG_LONG_LIMIT  = 2'd2;

   localparam int DEBOUNCE_W = 16;
   localparam int LIMIT_W    = 32;
   localparam int PEND_OUT_W = 8;

   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd2;
   localparam logic [LIMIT_W-1:0]    SHORT_RESET    = 32'd100;
   localparam logic [LIMIT_W-1:0]    LONG_RESET     = 32'd300;

   // Level on an edge request: low means pressed
   localparam logic PIN_PRESSED = 1'b0;

   // Registered request handed from the input stage to the tracker
   typedef struct packed {
      logic       valid;
      logic [1:0] cmd;
      logic       pin_level;
   } item_type;

   // One configuration write
   typedef struct packed {
      logic               valid;
      logic [1:0]         index;
      logic [LIMIT_W-1:0] data;
   } csr_write_type;

   // Result of one poll
   typedef struct packed {
      logic [1:0]            event_res;
      logic [PEND_OUT_W-1:0] pending_left;
   } result_type;

endpackage

`default_nettype wire

// File: src/bpdc_in_stage.sv
// Input register of the classifier: holds one request until the tracker takes it.
// Depends on bpdc_pkg.
`default_nettype none

module bpdc_in_stage import bpdc_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [0] pin_level, [7:1] zero
   input  wire logic [1:0] req_tuser,   // [1:0] cmd
   input  wire logic       out_space,
   output item_type        item
);

   logic       valid_ff, valid_in;
   logic [1:0] cmd_ff;
   logic       pin_ff;
   logic       go;

   // A poll needs room in the result register; ticks and edges always go
   assign go         = valid_ff && ((cmd_ff != CMD_POLL) || out_space);
   assign req_tready = !valid_ff || go;
   assign valid_in   = req_tvalid || (valid_ff && !go);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load a new request whenever the register frees up
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         cmd_ff <= req_tuser;
         pin_ff <= req_tdata[0];
      end
   end

   assign item.valid     = go;
   assign item.cmd       = cmd_ff;
   assign item.pin_level = pin_ff;

endmodule

`default_nettype wire

// File: src/bpdc_tracker.sv
// Time base, debounce, press tracking and classification of the classifier.
// Holds the configuration registers. Depends on bpdc_pkg.
`default_nettype none

module bpdc_tracker import bpdc_pkg::*; #(
   parameter int TIME_WIDTH  = 32,
   parameter int COUNT_WIDTH = 8
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire csr_write_type csr,
   input  wire item_type      item,
   output logic               res_valid,
   output result_type         res
);

   localparam int CMP_W = (TIME_WIDTH > LIMIT_W) ? TIME_WIDTH : LIMIT_W;
   localparam logic [COUNT_WIDTH-1:0] PEND_MAX = {COUNT_WIDTH{1'b1}};

   logic [DEBOUNCE_W-1:0]  debounce_ff;
   logic [LIMIT_W-1:0]     short_ff, long_ff;
   logic [TIME_WIDTH-1:0]  time_ff, time_in;
   logic [TIME_WIDTH-1:0]  last_edge_ff, last_edge_in;
   logic [TIME_WIDTH-1:0]  start_ff, start_in;
   logic                   pressed_ff, pressed_in;
   logic [TIME_WIDTH-1:0]  dur_ff, dur_in;
   logic [COUNT_WIDTH-1:0] pend_ff, pend_in;
   logic [TIME_WIDTH-1:0]  gap;
   logic                   edge_ok;
   logic [CMP_W-1:0]       dur_ext;
   logic [1:0]             ev;
   logic [1:0]             ev_res;
   logic [PEND_OUT_W-1:0]  pend_sat;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         short_ff    <= SHORT_RESET;
         long_ff     <= LONG_RESET;
      end else if (csr.valid) begin
         unique case (csr.index)
            REG_DEBOUNCE:    debounce_ff <= csr.data[DEBOUNCE_W-1:0];
            REG_SHORT_LIMIT: short_ff    <= csr.data;
            REG_LONG_LIMIT:  long_ff     <= csr.data;
            default: ;
         endcase
      end
   end

   // Debounce against the last accepted edge, modulo the counter width
   assign gap     = time_ff - last_edge_ff;
   assign edge_ok = gap >= TIME_WIDTH'(debounce_ff);

   // Classify the latest stored duration
   assign dur_ext = CMP_W'(dur_ff);
   always_comb begin
      if (dur_ext < CMP_W'(short_ff)) begin
         ev = EV_SHORT;
      end else if (dur_ext < CMP_W'(long_ff)) begin
         ev = EV_LONG;
      end else begin
         ev = EV_STOP;
      end
   end

   // Next state for the request in hand
   always_comb begin
      time_in      = time_ff;
      last_edge_in = last_edge_ff;
      start_in     = start_ff;
      pressed_in   = pressed_ff;
      dur_in       = dur_ff;
      pend_in      = pend_ff;
      res_valid    = 1'b0;
      ev_res       = EV_NONE;
      if (item.valid) begin
         case (item.cmd)
            CMD_TICK: time_in = time_ff + 1'b1;
            CMD_EDGE: begin
               if (edge_ok) begin
                  last_edge_in = time_ff;
                  if (item.pin_level == PIN_PRESSED) begin
                     start_in   = time_ff;
                     pressed_in = 1'b1;
                  end else if (pressed_ff) begin
                     dur_in     = time_ff - start_ff;
                     pressed_in = 1'b0;
                     if (pend_ff != PEND_MAX) begin
                        pend_in = pend_ff + 1'b1;
                     end
                  end
               end
            end
            CMD_POLL: begin
               res_valid = 1'b1;
               if (pend_ff != '0) begin
                  pend_in = pend_ff - 1'b1;
                  ev_res  = ev;
               end
            end
            default: ;
         endcase
      end
   end

   // Report the count left, saturated to the output field
   generate
      if (COUNT_WIDTH > PEND_OUT_W) begin : g_sat
         assign pend_sat = (pend_in > COUNT_WIDTH'({PEND_OUT_W{1'b1}}))
                           ? {PEND_OUT_W{1'b1}} : pend_in[PEND_OUT_W-1:0];
      end else begin : g_ext
         assign pend_sat = PEND_OUT_W'(pend_in);
      end
   endgenerate

   assign res = {ev_res, pend_sat};

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff      <= '0;
         last_edge_ff <= '0;
         start_ff     <= '0;
         pressed_ff   <= 1'b0;
         dur_ff       <= '0;
         pend_ff      <= '0;
      end else begin
         time_ff      <= time_in;
         last_edge_ff <= last_edge_in;
         start_ff     <= start_in;
         pressed_ff   <= pressed_in;
         dur_ff       <= dur_in;
         pend_ff      <= pend_in;
      end
   end

endmodule

`default_nettype wire

// File: src/bpdc_out_stage.sv
// Result register of the classifier: holds one poll result until it is taken.
// Depends on bpdc_pkg.
`default_nettype none

module bpdc_out_stage import bpdc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        res_valid,
   input  wire result_type  res,
   output logic             out_space,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata   // [1:0] event_res, [9:2] pending_left, [15:10] zero
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   // Free when empty or being emptied this cycle
   assign out_space = !valid_ff || rsp_tready;
   assign valid_in  = res_valid || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture a new result; the input stage only sends one when there is room
   always_ff @(posedge clock) begin
      if (res_valid) begin
         data_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {6'd0, data_ff.pending_left, data_ff.event_res};

endmodule

`default_nettype wire

// File: src/button_press_duration_classifier.sv
// Top level of the button press duration classifier.
// Depends on bpdc_pkg, bpdc_in_stage, bpdc_tracker and bpdc_out_stage.
//
// Usage:
//   req_*  : one request per handshake; req_tuser is the kind (tick, pin edge,
//            poll) and req_tdata[0] the pin level on an edge (0 pressed).
//   rsp_*  : one result per poll, nothing for ticks and edges; rsp_tdata
//            carries the classification and the presses still waiting.
//   csr_*  : register writes (0 debounce, 1 short limit, 2 long limit);
//            always ready, meant for idle periods.
// Timing: a request is registered at its handshake and processed from that
//   register once it may go; a poll result is then registered in the result
//   register, which drives rsp_tvalid.
//   One request per cycle is sustained while no poll waits on a full result
//   register; the tracker handles each request as it arrives, with no busy state.
// Reset: clears time, press state, pending count and both pipeline registers,
//   and loads the register defaults 2, 100 and 300 ticks.
// Stall: while a result waits, ticks and edges still go through; a poll waits
//   in the input register, and req_tready drops once that register is held.
`default_nettype none

module button_press_duration_classifier import bpdc_pkg::*; #(
   parameter int TIME_WIDTH  = 32,
   parameter int COUNT_WIDTH = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [0] pin_level, [7:1] zero
   input  wire logic [1:0]  req_tuser,   // [1:0] cmd
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [1:0] event_res, [9:2] pending_left, [15:10] zero
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   item_type      item;
   csr_write_type csr;
   result_type    res;
   logic          res_valid;
   logic          out_space;

   assign csr_ready = 1'b1;
   assign csr = {csr_valid, csr_index, csr_data};

   bpdc_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .out_space  (out_space),
      .item       (item)
   );

   bpdc_tracker #(
      .TIME_WIDTH  (TIME_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_tracker (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .item      (item),
      .res_valid (res_valid),
      .res       (res)
   );

   bpdc_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .res        (res),
      .out_space  (out_space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

// File: src/bpdc_checker.sv
// Port-level checks for the button press duration classifier, bound to the top.
// Depends on bpdc_pkg and button_press_duration_classifier.
`default_nettype none

module bpdc_checker import bpdc_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Drop any result on reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result visible after reset");

   // An empty poll reports nothing waiting
   a_none_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] == EV_NONE |-> rsp_tdata[9:2] == 8'd0)
      else $error("empty poll with presses left");

   // A fresh result needs an accepted request, registered in the input and result registers
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result without a request");

endmodule

bind button_press_duration_classifier bpdc_checker u_bpdc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
